// ----- sv/npc_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, types and codes of the nearest profile classifier
package npc_pkg;

  localparam int MAX_PROFILES = 16;
  localparam int FEATURES     = 9;

  // field widths fixed by the stream format
  localparam int ACT_W   = 2;
  localparam int IDX_W   = 4;
  localparam int FIDX_W  = 4;
  localparam int VAL_W   = 7;
  localparam int DIST_W  = 9;
  localparam int CONF_W  = 10;
  localparam int LVL_W   = 2;
  localparam int CFG_W   = 5;
  localparam int IN_DW   = 16;
  localparam int OUT_DW  = 32;

  // derived sizes
  localparam int PROF_W    = (MAX_PROFILES > 1) ? $clog2(MAX_PROFILES) : 1;
  localparam int FEAT_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int REF_DEPTH = MAX_PROFILES * FEATURES;
  localparam int REF_AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
  localparam int SQ_W      = 2 * VAL_W;
  localparam int SUM_MAX   = FEATURES * ((1 << VAL_W) - 1) * ((1 << VAL_W) - 1);
  localparam int SUM_W     = $clog2(SUM_MAX + 1);
  localparam int ROOT_W    = (SUM_W + 1) / 2;
  localparam int ROOT_BIT0 = 2 * (ROOT_W - 1);

  // confidence scaling: floor((300 - r) * 10 / 3) as a reciprocal multiply
  localparam int CONF_BASE  = 300;
  localparam int CONF_MUL   = 436910;
  localparam int CONF_MUL_W = 19;
  localparam int CONF_SHIFT = 17;
  localparam int CONF_HIGH  = 800;
  localparam int CONF_MED   = 600;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(9);

  typedef enum logic [ACT_W-1:0] {
    ACT_REF_WRITE    = 2'd0,
    ACT_SAMPLE_WRITE = 2'd1,
    ACT_CLASSIFY     = 2'd2,
    ACT_NONE         = 2'd3
  } action_t;

  typedef enum logic [LVL_W-1:0] {
    LVL_LOW    = 2'd0,
    LVL_MEDIUM = 2'd1,
    LVL_HIGH   = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] root;
  } root_res_t;

endpackage

// ----- sv/npc_ref_mem.sv -----
`timescale 1ns / 1ps
// reference feature memory, one write port and one registered read port
module npc_ref_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [npc_pkg::REF_AW-1:0]  wr_addr,
  input  logic [npc_pkg::VAL_W-1:0]   wr_data,
  input  logic [npc_pkg::REF_AW-1:0]  rd_addr,
  output logic [npc_pkg::VAL_W-1:0]   rd_data
);

  logic [npc_pkg::VAL_W-1:0] mem [npc_pkg::REF_DEPTH];
  logic [npc_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sv/npc_root.sv -----
`timescale 1ns / 1ps
// iterative integer square root, two bits of the radicand per cycle
module npc_root (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [npc_pkg::SUM_W-1:0]  value,
  output npc_pkg::root_res_t         res
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [npc_pkg::SUM_W-1:0]  rem_r, rem_nxt;
  logic [npc_pkg::SUM_W-1:0]  acc_r, acc_nxt;
  logic [npc_pkg::SUM_W-1:0]  bit_r, bit_nxt;
  logic [npc_pkg::SUM_W:0]    trial;

  assign trial = {1'b0, acc_r} + {1'b0, bit_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    bit_nxt  = bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = value;
      acc_nxt  = '0;
      bit_nxt  = npc_pkg::SUM_W'(1) << npc_pkg::ROOT_BIT0;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[npc_pkg::SUM_W-1:0];
        acc_nxt = (acc_r >> 1) + bit_r;
      end else begin
        acc_nxt = acc_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      // last step when the trial bit sits at the bottom
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    bit_r <= bit_nxt;
  end

  assign res.done = done_r;
  assign res.root = acc_r[npc_pkg::DIST_W-1:0];

endmodule

// ----- sv/nearest_profile_classifier.sv -----
`timescale 1ns / 1ps
// top level of the nearest profile classifier: stream ports, scan sequencer, result stage
//
//  channel  direction  beat content
//  in_      slave      tuser: action; tdata: profile_index, feature_index, feature_value
//  out_     master     tdata: best_index, distance_root, confidence_tenths, quality_level
//  cfg_     write      profiles_in_use, 5 bits, no read-back
//
// write beats (reference or sample feature) are taken back to back while idle
// a classify beat scans the N profiles in use, one reference
//   read per cycle through the single memory port, then runs a 9-step square root
// in_tready stays low from a classify beat until its result is loaded into the
//   output register; the output register lets the next beat in while it waits
// rst_n is synchronous, active low; the reference memory is not cleared
// a stalled result holds the sequencer in its last state until taken
module nearest_profile_classifier (
  input  logic                         clk,
  input  logic                         rst_n,
  // beat: [3:0] profile_index, [7:4] feature_index, [14:8] feature_value, [15] zero
  input  logic [npc_pkg::IN_DW-1:0]    in_tdata,
  // beat: [1:0] action
  input  logic [npc_pkg::ACT_W-1:0]    in_tuser,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // beat: [3:0] best_index, [12:4] distance_root, [22:13] confidence_tenths,
  //       [24:23] quality_level, [31:25] zero
  output logic [npc_pkg::OUT_DW-1:0]   out_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_we,
  input  logic [npc_pkg::CFG_W-1:0]    cfg_wdata
);

  // input fields
  npc_pkg::action_t                 in_act;
  logic [npc_pkg::IDX_W-1:0]        in_prof;
  logic [npc_pkg::FIDX_W-1:0]       in_feat;
  logic [npc_pkg::VAL_W-1:0]        in_val;
  logic                             in_beat;

  assign in_act  = npc_pkg::action_t'(in_tuser);
  assign in_prof = in_tdata[3:0];
  assign in_feat = in_tdata[7:4];
  assign in_val  = in_tdata[14:8];
  assign in_beat = in_tvalid && in_tready;

  // configuration
  logic [npc_pkg::CFG_W-1:0]  cfg_r;
  logic [npc_pkg::PROF_W-1:0] last_prof;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= npc_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // zero counts as one profile, anything above the table size as the full table
  always_comb begin
    if (cfg_r == '0) begin
      last_prof = '0;
    end else if (32'(cfg_r) > npc_pkg::MAX_PROFILES) begin
      last_prof = npc_pkg::PROF_W'(npc_pkg::MAX_PROFILES - 1);
    end else begin
      last_prof = npc_pkg::PROF_W'(cfg_r - 1'b1);
    end
  end

  // sample store, cleared by reset
  logic [npc_pkg::VAL_W-1:0] sample_r [npc_pkg::FEATURES];
  logic feat_ok, prof_ok;

  assign feat_ok = 32'(in_feat) < npc_pkg::FEATURES;
  assign prof_ok = 32'(in_prof) < npc_pkg::MAX_PROFILES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < npc_pkg::FEATURES; i++) begin
        sample_r[i] <= '0;
      end
    end else if (in_beat && in_act == npc_pkg::ACT_SAMPLE_WRITE && feat_ok) begin
      sample_r[in_feat[npc_pkg::FEAT_W-1:0]] <= in_val;
    end
  end

  // sequencer
  npc_pkg::state_t state_r, state_nxt;
  logic [npc_pkg::PROF_W-1:0] p_r, p_nxt;
  logic [npc_pkg::FEAT_W-1:0] f_r, f_nxt;
  logic [npc_pkg::REF_AW-1:0] addr_r, addr_nxt;
  logic issue, root_start, out_load, out_free;
  logic last_feat, last_issue;

  // pipeline: stage 1 holds the operands, stage 2 the square
  logic                       s1_v_r, s1_last_r;
  logic [npc_pkg::PROF_W-1:0] s1_p_r;
  logic [npc_pkg::VAL_W-1:0]  s1_samp_r;
  logic [npc_pkg::VAL_W-1:0]  ref_q;
  logic                       s2_v_r, s2_last_r;
  logic [npc_pkg::PROF_W-1:0] s2_p_r;
  logic [npc_pkg::SQ_W-1:0]   s2_sq_r;
  logic [npc_pkg::VAL_W-1:0]  abs_diff;

  logic [npc_pkg::SUM_W-1:0]  sum_r, acc;
  logic [npc_pkg::SUM_W-1:0]  best_sum_r;
  logic [npc_pkg::PROF_W-1:0] best_r;

  npc_pkg::root_res_t root_res;

  logic out_valid_r;

  assign last_feat  = 32'(f_r) == npc_pkg::FEATURES - 1;
  assign last_issue = last_feat && (p_r == last_prof);
  assign out_free   = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npc_pkg::ST_IDLE: begin
        if (in_beat && in_act == npc_pkg::ACT_CLASSIFY) begin
          state_nxt = npc_pkg::ST_SCAN;
        end
      end
      npc_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_nxt = npc_pkg::ST_DRAIN;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (!s1_v_r && !s2_v_r) begin
          state_nxt = npc_pkg::ST_ROOT;
        end
      end
      npc_pkg::ST_ROOT: begin
        if (root_res.done) begin
          state_nxt = npc_pkg::ST_DONE;
        end
      end
      npc_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = npc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    issue      = 1'b0;
    root_start = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      npc_pkg::ST_IDLE:  in_tready  = 1'b1;
      npc_pkg::ST_SCAN:  issue      = 1'b1;
      npc_pkg::ST_DRAIN: root_start = !s1_v_r && !s2_v_r;
      npc_pkg::ST_ROOT:  ;
      npc_pkg::ST_DONE:  out_load   = out_free;
      default:           ;
    endcase
  end

  // scan counters walk profile by profile, feature by feature
  always_comb begin
    p_nxt    = p_r;
    f_nxt    = f_r;
    addr_nxt = addr_r;
    if (state_r == npc_pkg::ST_IDLE) begin
      p_nxt    = '0;
      f_nxt    = '0;
      addr_nxt = '0;
    end else if (issue) begin
      addr_nxt = addr_r + 1'b1;
      if (last_feat) begin
        f_nxt = '0;
        p_nxt = p_r + 1'b1;
      end else begin
        f_nxt = f_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npc_pkg::ST_IDLE;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    f_r       <= f_nxt;
    addr_r    <= addr_nxt;
    s1_last_r <= last_feat;
    s1_p_r    <= p_r;
    s1_samp_r <= sample_r[f_r];
    s2_last_r <= s1_last_r;
    s2_p_r    <= s1_p_r;
    s2_sq_r   <= npc_pkg::SQ_W'(abs_diff) * npc_pkg::SQ_W'(abs_diff);
  end

  // reference memory: written by reference beats, read by the scan
  logic                       ref_we;
  logic [npc_pkg::REF_AW-1:0] ref_waddr;

  assign ref_we    = in_beat && in_act == npc_pkg::ACT_REF_WRITE && prof_ok && feat_ok;
  assign ref_waddr = npc_pkg::REF_AW'(32'(in_prof) * npc_pkg::FEATURES)
                   + npc_pkg::REF_AW'(in_feat);

  npc_ref_mem u_ref_mem (
    .clk     (clk),
    .wr_en   (ref_we),
    .wr_addr (ref_waddr),
    .wr_data (in_val),
    .rd_addr (addr_r),
    .rd_data (ref_q)
  );

  assign abs_diff = (s1_samp_r >= ref_q) ? (s1_samp_r - ref_q) : (ref_q - s1_samp_r);

  // accumulate per profile; keep the first strict minimum, profile 0 always seeds it
  assign acc = sum_r + npc_pkg::SUM_W'(s2_sq_r);

  always_ff @(posedge clk) begin
    if (state_r == npc_pkg::ST_IDLE) begin
      sum_r <= '0;
    end else if (s2_v_r) begin
      if (s2_last_r) begin
        sum_r <= '0;
        if (s2_p_r == '0 || acc < best_sum_r) begin
          best_sum_r <= acc;
          best_r     <= s2_p_r;
        end
      end else begin
        sum_r <= acc;
      end
    end
  end

  npc_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .value (best_sum_r),
    .res   (root_res)
  );

  // confidence and level from the root
  logic [npc_pkg::DIST_W-1:0]                    root_q;
  logic [npc_pkg::DIST_W-1:0]                    conf_base_diff;
  logic [npc_pkg::DIST_W+npc_pkg::CONF_MUL_W-1:0] conf_prod;
  logic [npc_pkg::CONF_W-1:0]                    conf;
  npc_pkg::level_t                               level;

  assign root_q = root_res.root;

  always_comb begin
    if (32'(root_q) < npc_pkg::CONF_BASE) begin
      conf_base_diff = npc_pkg::DIST_W'(npc_pkg::CONF_BASE) - root_q;
    end else begin
      conf_base_diff = '0;
    end
    conf_prod = (npc_pkg::DIST_W + npc_pkg::CONF_MUL_W)'(conf_base_diff)
              * (npc_pkg::DIST_W + npc_pkg::CONF_MUL_W)'(npc_pkg::CONF_MUL);
    conf = conf_prod[npc_pkg::CONF_SHIFT +: npc_pkg::CONF_W];
    if (32'(conf) >= npc_pkg::CONF_HIGH) begin
      level = npc_pkg::LVL_HIGH;
    end else if (32'(conf) >= npc_pkg::CONF_MED) begin
      level = npc_pkg::LVL_MEDIUM;
    end else begin
      level = npc_pkg::LVL_LOW;
    end
  end

  // output register
  logic [npc_pkg::OUT_DW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {7'd0, level, conf, root_q, npc_pkg::IDX_W'(best_r)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/npc_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the nearest profile classifier and their bind
module npc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic [npc_pkg::ACT_W-1:0]   in_tuser,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [npc_pkg::OUT_DW-1:0]  out_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready
);

  logic [npc_pkg::DIST_W-1:0] root_f;
  logic [npc_pkg::CONF_W-1:0] conf_f;
  logic [npc_pkg::LVL_W-1:0]  lvl_f;

  assign root_f = out_tdata[12:4];
  assign conf_f = out_tdata[22:13];
  assign lvl_f  = out_tdata[24:23];

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a classify beat blocks the input for the following cycle
  a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == npc_pkg::ACT_CLASSIFY |=> !in_tready)
    else $error("input taken during classify");

  // level agrees with confidence
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ((32'(conf_f) >= npc_pkg::CONF_HIGH) == (lvl_f == npc_pkg::LVL_HIGH)) &&
      ((32'(conf_f) < npc_pkg::CONF_MED) == (lvl_f == npc_pkg::LVL_LOW)))
    else $error("level does not match confidence");

  // confidence vanishes exactly when the root reaches the base distance
  a_conf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((32'(root_f) >= npc_pkg::CONF_BASE) == (conf_f == '0)))
    else $error("confidence does not match root");

endmodule

bind nearest_profile_classifier npc_checker u_npc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tuser   (in_tuser),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// ----- verif/nearest_profile_classifier_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the nearest profile classifier: stream stimulus and scoreboard
module nearest_profile_classifier_tb;
  import npc_pkg::*;

  // stimulus size and pacing
  localparam int RANDOM_ITEMS  = 1760;
  localparam int QUIET_TAIL    = 150;   // last beats of the run go without any idling
  localparam int PHASE_ITEMS   = 300;   // beats between profile count changes
  localparam int SETTLE_CYCLES = 20;    // quiet cycles before a register write
  localparam int DRAIN_CYCLES  = 200;   // longer than one full classify scan
  localparam int TIMEOUT_NS    = 20_000_000;

  // one classify verdict as the output beat carries it
  typedef struct {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] distance_root;
    logic [CONF_W-1:0] confidence_tenths;
    level_t            quality_level;
  } verdict_t;

  // mirror of the reference and sample stores, predicts each classify verdict
  class classify_scoreboard;
    logic [VAL_W-1:0] ref_feature [MAX_PROFILES][FEATURES];
    logic [VAL_W-1:0] sample_feature [FEATURES];
    int unsigned      profiles_in_use;
    verdict_t         pending_verdicts [$];
    int               failures;
    int               verdicts_checked;
    int               level_count [3];

    function new();
      foreach (ref_feature[p, f]) ref_feature[p][f] = '0;
      foreach (sample_feature[f]) sample_feature[f] = '0;
      profiles_in_use  = CFG_RESET;
      failures         = 0;
      verdicts_checked = 0;
      foreach (level_count[i]) level_count[i] = 0;
    endfunction

    function void set_profiles(logic [CFG_W-1:0] value);
      profiles_in_use = value;
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    // apply one accepted input beat; a classify queues its expected verdict
    function void note_beat(action_t act, logic [IDX_W-1:0] pidx, logic [FIDX_W-1:0] fidx,
                            logic [VAL_W-1:0] val);
      int unsigned count, best, best_sum, sum, diff, root, trial, conf;
      verdict_t    v;
      case (act)
        ACT_REF_WRITE: begin
          if (pidx < MAX_PROFILES && fidx < FEATURES) ref_feature[pidx][fidx] = val;
        end
        ACT_SAMPLE_WRITE: begin
          if (fidx < FEATURES) sample_feature[fidx] = val;
        end
        ACT_CLASSIFY: begin
          // zero counts as one profile, oversized counts saturate
          count = profiles_in_use;
          if (count == 0) count = 1;
          if (count > MAX_PROFILES) count = MAX_PROFILES;
          best     = 0;
          best_sum = 0;
          for (int p = 0; p < count; p++) begin
            sum = 0;
            for (int f = 0; f < FEATURES; f++) begin
              diff = (sample_feature[f] > ref_feature[p][f]) ?
                     sample_feature[f] - ref_feature[p][f] :
                     ref_feature[p][f] - sample_feature[f];
              sum += diff * diff;
            end
            // strict compare keeps the lowest index on a tie
            if (p == 0 || sum < best_sum) begin
              best_sum = sum;
              best     = p;
            end
          end
          // floor square root, one result bit at a time
          root = 0;
          for (int b = DIST_W - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= best_sum) root = trial;
          end
          conf = (root < CONF_BASE) ? ((CONF_BASE - root) * 10) / 3 : 0;
          v.best_index        = best[IDX_W-1:0];
          v.distance_root     = root[DIST_W-1:0];
          v.confidence_tenths = conf[CONF_W-1:0];
          v.quality_level     = (conf >= CONF_HIGH) ? LVL_HIGH :
                                (conf >= CONF_MED) ? LVL_MEDIUM : LVL_LOW;
          pending_verdicts.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    // compare one accepted output beat with the oldest queued verdict
    function void check_result(logic [OUT_DW-1:0] beat);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("result beat %h with no classify outstanding", beat);
        failures++;
        return;
      end
      v = pending_verdicts.pop_front();
      compare_field("best_index", v.best_index, beat[3:0]);
      compare_field("distance_root", v.distance_root, beat[12:4]);
      compare_field("confidence_tenths", v.confidence_tenths, beat[22:13]);
      compare_field("quality_level", v.quality_level, beat[24:23]);
      compare_field("padding", 0, beat[OUT_DW-1:25]);
      verdicts_checked++;
      level_count[v.quality_level]++;
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic [IN_DW-1:0]    in_tdata  = '0;
  logic [ACT_W-1:0]    in_tuser  = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic                cfg_we     = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;

  classify_scoreboard  sb = new();

  bit quiet        = 1'b0;   // no idling on either side
  bit sender_idles = 1'b0;   // current sequence may insert gaps
  int beats_counted = 0;     // beats that change state or ask for a verdict
  int settings_used = 0;

  // profile counts walked through by the random phases, extremes first
  logic [CFG_W-1:0] phase_settings [7] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd12, 5'd17};

  nearest_profile_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly nominal feature values, now and then above 100
  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 9) == 0) return VAL_W'($urandom_range(101, 127));
    return VAL_W'($urandom_range(0, 100));
  endfunction

  // drive one input beat and hold it until the block takes it
  task automatic send_beat(action_t act, logic [IDX_W-1:0] pidx, logic [FIDX_W-1:0] fidx,
                           logic [VAL_W-1:0] val);
    int gap;
    gap = 0;
    if (!quiet && sender_idles && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= IN_DW'({val, fidx, pidx});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(act, pidx, fidx, val);
    if (act == ACT_CLASSIFY || (act != ACT_NONE && fidx < FEATURES)) beats_counted++;
  endtask

  // drop valid, let every verdict arrive, then give the block some quiet cycles
  task automatic wait_idle(int cycles);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_profiles_in_use(logic [CFG_W-1:0] value);
    wait_idle(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_profiles(value);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // result side: check every taken beat, stall in random bursts
  initial begin
    int stall_left;
    bit stall_mode;
    stall_left = 0;
    stall_mode = 1'b1;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
      if (quiet) begin
        stall_left = 0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (stall_mode && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
      // switch between stalling stretches and free-running stretches
      if ($urandom_range(0, 199) == 0) stall_mode = !stall_mode;
    end
  end

  initial begin
    int base, done, next_phase, kind, k, p, n, v;
    logic [IDX_W-1:0] ref_p;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // preload every reference entry so no classify reads an unwritten one;
    // profiles 0 and 1 are identical (tie), profile 15 sits at the top of the range
    sender_idles = 1'b1;
    for (int pp = 0; pp < MAX_PROFILES; pp++) begin
      for (int f = 0; f < FEATURES; f++) begin
        if (pp <= 1) send_beat(ACT_REF_WRITE, IDX_W'(pp), FIDX_W'(f), '0);
        else if (pp == MAX_PROFILES - 1)
          send_beat(ACT_REF_WRITE, IDX_W'(pp), FIDX_W'(f), VAL_W'(100));
        else send_beat(ACT_REF_WRITE, IDX_W'(pp), FIDX_W'(f), pick_value());
      end
    end

    // directed: zero sample against the tied zero profiles, default count of nine
    send_beat(ACT_CLASSIFY, '0, '0, '0);
    // ignored beats: reserved action, feature index out of range on both stores
    send_beat(ACT_NONE, '1, '1, '1);
    send_beat(ACT_REF_WRITE, 4'd15, 4'd15, 7'd127);
    send_beat(ACT_SAMPLE_WRITE, 4'd0, 4'd9, 7'd127);
    send_beat(ACT_CLASSIFY, '0, '0, '0);
    // sample at the largest value on every feature
    for (int f = 0; f < FEATURES; f++) send_beat(ACT_SAMPLE_WRITE, '1, FIDX_W'(f), 7'd127);
    send_beat(ACT_CLASSIFY, '0, '0, '0);
    // count above the maximum saturates, profile 15 then wins
    write_profiles_in_use(5'd31);
    send_beat(ACT_CLASSIFY, '0, '0, '0);
    // single profile, then zero that behaves as one
    write_profiles_in_use(5'd1);
    send_beat(ACT_CLASSIFY, '0, '0, '0);
    write_profiles_in_use(5'd0);
    send_beat(ACT_CLASSIFY, '0, '0, '0);
    send_beat(ACT_SAMPLE_WRITE, '0, 4'd0, 7'd0);
    send_beat(ACT_SAMPLE_WRITE, '0, 4'd8, 7'd100);
    send_beat(ACT_CLASSIFY, '0, '0, '0);

    // random phases of well-formed sequences with some noise in between
    base       = beats_counted;
    done       = 0;
    next_phase = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= next_phase) begin
        if (settings_used - 3 < $size(phase_settings))
          write_profiles_in_use(phase_settings[settings_used - 3]);
        else write_profiles_in_use(CFG_W'($urandom_range(0, 31)));
        next_phase += PHASE_ITEMS;
      end
      if (done >= RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      sender_idles = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // sample close to one profile, spread chosen per sequence
        case ($urandom_range(0, 3))
          0: k = 0;
          1: k = 3;
          2: k = 10;
          default: k = 40;
        endcase
        ref_p = IDX_W'($urandom_range(0, MAX_PROFILES - 1));
        for (int f = 0; f < FEATURES; f++) begin
          v = int'(sb.ref_feature[ref_p][f]) + int'($urandom_range(0, 2 * k)) - k;
          if (v < 0) v = 0;
          if (v > 127) v = 127;
          send_beat(ACT_SAMPLE_WRITE, IDX_W'($urandom), FIDX_W'(f), VAL_W'(v));
        end
        send_beat(ACT_CLASSIFY, IDX_W'($urandom), FIDX_W'($urandom), VAL_W'($urandom));
      end else if (kind < 65) begin
        // touch a few sample features
        n = $urandom_range(1, 4);
        repeat (n) send_beat(ACT_SAMPLE_WRITE, IDX_W'($urandom),
                             FIDX_W'($urandom_range(0, FEATURES - 1)), pick_value());
        send_beat(ACT_CLASSIFY, '0, '0, '0);
      end else if (kind < 80) begin
        // retrain a few reference entries
        n = $urandom_range(1, 6);
        repeat (n) send_beat(ACT_REF_WRITE, IDX_W'($urandom_range(0, MAX_PROFILES - 1)),
                             FIDX_W'($urandom_range(0, FEATURES - 1)), pick_value());
        send_beat(ACT_CLASSIFY, '0, '0, '0);
      end else if (kind < 90) begin
        // noise: beats the block must ignore, then at random a classify to show nothing moved
        case ($urandom_range(0, 2))
          0: send_beat(ACT_NONE, IDX_W'($urandom), FIDX_W'($urandom), VAL_W'($urandom));
          1: send_beat(ACT_REF_WRITE, IDX_W'($urandom),
                       FIDX_W'($urandom_range(FEATURES, 15)), VAL_W'($urandom));
          default: send_beat(ACT_SAMPLE_WRITE, IDX_W'($urandom),
                             FIDX_W'($urandom_range(FEATURES, 15)), VAL_W'($urandom));
        endcase
        if ($urandom_range(0, 1) == 0) send_beat(ACT_CLASSIFY, '0, '0, '0);
      end else begin
        // classify beats back to back, fields of a classify carry no meaning
        n = $urandom_range(2, 3);
        repeat (n) send_beat(ACT_CLASSIFY, IDX_W'($urandom), FIDX_W'($urandom),
                             VAL_W'($urandom));
      end
      done = beats_counted - base;
    end

    wait_idle(DRAIN_CYCLES);
    $display("run covered %0d counted beats over %0d profile count settings",
             beats_counted, settings_used);
    $display("verdicts checked %0d: high %0d, medium %0d, low %0d", sb.verdicts_checked,
             sb.level_count[LVL_HIGH], sb.level_count[LVL_MEDIUM], sb.level_count[LVL_LOW]);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
